>>> hdl/vole_pkg.sv
`default_nettype none
package vole_pkg;
  localparam int MEM_DEPTH = 256;
  localparam int MEM_AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int REG_COUNT = 16;
  localparam logic [7:0] START_RESET = 8'd10;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_EXEC  = 2'd1;
  localparam logic [1:0] FUNC_RDMEM = 2'd2;
  localparam logic [1:0] FUNC_RDREG = 2'd3;

  localparam logic [3:0] OP_LOAD  = 4'h1;
  localparam logic [3:0] OP_LDI   = 4'h2;
  localparam logic [3:0] OP_STORE = 4'h3;
  localparam logic [3:0] OP_MOVE  = 4'h4;
  localparam logic [3:0] OP_ADD   = 4'h5;
  localparam logic [3:0] OP_FADD  = 4'h6;
  localparam logic [3:0] OP_OR    = 4'h7;
  localparam logic [3:0] OP_AND   = 4'h8;
  localparam logic [3:0] OP_XOR   = 4'h9;
  localparam logic [3:0] OP_ROT   = 4'hA;
  localparam logic [3:0] OP_JEQ   = 4'hB;
  localparam logic [3:0] OP_HALT  = 4'hC;
  localparam logic [3:0] OP_JGT   = 4'hD;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       cap_in;     // latch the input word
    logic       mem_rd_a;   // read memory at item address
    logic       mem_rd_pc;  // read memory at pc
    logic       mem_rd_pc1; // read memory at pc+1
    logic       mem_rd_lo;  // read memory at instruction low byte
    logic       mem_wr_in;  // write input data
    logic       cap_hi;     // latch hi byte
    logic       cap_lo;     // latch lo byte
    logic       execute;    // commit instruction
    logic       finish;     // present result
  } vole_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       halted;
    logic [3:0] op;
  } vole_stat_t;

  function automatic logic [7:0] float_add(input logic [7:0] a, input logic [7:0] b);
    logic [11:0] ma, mb, mag;
    logic [12:0] sa, sb, sum;
    logic [2:0]  e;
    logic [3:0]  m;
    logic [3:0]  p;
    ma = 12'(a[3:0]) << a[6:4];
    mb = 12'(b[3:0]) << b[6:4];
    sa = a[7] ? -{1'b0, ma} : {1'b0, ma};
    sb = b[7] ? -{1'b0, mb} : {1'b0, mb};
    sum = sa + sb;
    mag = sum[12] ? 12'(-sum) : sum[11:0];
    p = 4'd0;
    for (int i = 0; i < 12; i++) if (mag[i]) p = 4'(i);
    if (mag == 12'd0) return 8'h00;
    if (p <= 4'd3) begin
      e = 3'd0;
      m = mag[3:0];
    end else if (p - 4'd3 > 4'd7) begin
      e = 3'd7;
      m = 4'hF;
    end else begin
      e = 3'(p - 4'd3);
      m = 4'(mag >> e);
    end
    return {sum[12], e, m};
  endfunction
endpackage
`default_nettype wire

>>> hdl/vole_ram.sv
`default_nettype none
module vole_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> hdl/vole_datapath.sv
`default_nettype none
module vole_datapath (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire vole_pkg::vole_cmd_t cmd,
  output vole_pkg::vole_stat_t    stat,
  input  wire logic               clr_we,
  input  wire logic [7:0]         clr_addr,
  input  wire logic               cfg_we,
  input  wire logic [7:0]         cfg_data,
  input  wire logic [1:0]         in_func,
  input  wire logic [7:0]         in_address,
  input  wire logic [7:0]         in_data,
  output logic [7:0]              out_read_data,
  output logic [7:0]              out_program_counter,
  output logic [15:0]             out_instruction,
  output logic                    out_screen_valid,
  output logic [7:0]              out_screen_value,
  output logic                    out_halted,
  output logic                    out_bad_opcode
);
  import vole_pkg::*;

  logic [1:0]  func_r;
  logic [7:0]  addr_r, data_r, hi_r, lo_r, pc_r, pc_nxt;
  logic        halt_r;
  logic [7:0]  regs_r [REG_COUNT];
  logic        mem_we;
  logic [MEM_AW-1:0] mem_wa, mem_ra;
  logic [7:0]  mem_wd, mem_rd;
  logic [7:0]  rv, xv, yv, wb;
  logic        wb_en, jump, is_bad, scr_v;
  logic [3:0]  op, r, x, y, wb_idx;
  logic [7:0]  pc1;

  assign op = hi_r[7:4];
  assign r = hi_r[3:0];
  assign x = lo_r[7:4];
  assign y = lo_r[3:0];
  assign rv = regs_r[r];
  assign xv = regs_r[x];
  assign yv = regs_r[y];
  assign pc1 = pc_r + 8'd1;

  always_comb begin
    mem_ra = MEM_AW'(addr_r);
    if (cmd.mem_rd_pc) mem_ra = MEM_AW'(pc_r);
    else if (cmd.mem_rd_pc1) mem_ra = MEM_AW'(pc1);
    else if (cmd.mem_rd_lo) mem_ra = MEM_AW'(lo_r);
    else if (cmd.mem_rd_a) mem_ra = MEM_AW'(addr_r);
  end

  always_comb begin
    wb = 8'd0;
    wb_en = 1'b0;
    wb_idx = r;
    jump = 1'b0;
    is_bad = 1'b0;
    unique case (op)
      OP_LOAD:  begin wb = mem_rd; wb_en = 1'b1; end
      OP_LDI:   begin wb = lo_r; wb_en = 1'b1; end
      OP_STORE: ;
      OP_MOVE:  begin wb = xv; wb_en = 1'b1; wb_idx = y; end
      OP_ADD:   begin wb = xv + yv; wb_en = 1'b1; end
      OP_FADD:  begin wb = float_add(xv, yv); wb_en = 1'b1; end
      OP_OR:    begin wb = xv | yv; wb_en = 1'b1; end
      OP_AND:   begin wb = xv & yv; wb_en = 1'b1; end
      OP_XOR:   begin wb = xv ^ yv; wb_en = 1'b1; end
      OP_ROT:   begin wb = 8'({rv, rv} >> y[2:0]); wb_en = 1'b1; end
      OP_JEQ:   jump = (rv == regs_r[0]);
      OP_HALT:  ;
      OP_JGT:   jump = ($signed(rv) > $signed(regs_r[0]));
      default:  is_bad = 1'b1;
    endcase
  end

  assign pc_nxt = jump ? lo_r : pc_r + 8'd2;
  assign scr_v = (op == OP_STORE) && (lo_r == 8'd0);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = MEM_AW'(addr_r);
    mem_wd = data_r;
    if (clr_we) begin
      mem_we = 1'b1;
      mem_wa = MEM_AW'(clr_addr);
      mem_wd = 8'd0;
    end else if (cmd.mem_wr_in) begin
      mem_we = 1'b1;
    end else if (cmd.execute && op == OP_STORE) begin
      mem_we = 1'b1;
      mem_wa = MEM_AW'(lo_r);
      mem_wd = rv;
    end
  end

  vole_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_wa), .wdata(mem_wd),
    .raddr(mem_ra), .rdata(mem_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= START_RESET;
      halt_r <= 1'b0;
      out_screen_valid <= 1'b0;
      for (int i = 0; i < REG_COUNT; i++) regs_r[i] <= 8'd0;
    end else begin
      if (cmd.cap_in) begin
        func_r <= in_func;
        addr_r <= in_address;
        data_r <= in_data;
      end
      if (cmd.cap_hi) hi_r <= mem_rd;
      if (cmd.cap_lo) lo_r <= mem_rd;
      if (cfg_we) pc_r <= cfg_data;
      if (cmd.execute) begin
        if (wb_en) regs_r[wb_idx] <= wb;
        if (op == OP_HALT) halt_r <= 1'b1;
        pc_r <= pc_nxt;
      end
      if (cmd.finish) begin
        out_read_data <= (func_r == FUNC_RDMEM) ? mem_rd :
                         (func_r == FUNC_RDREG) ? regs_r[addr_r[3:0]] : 8'd0;
        out_instruction <= (cmd.execute) ? {hi_r, lo_r} : 16'd0;
        out_screen_valid <= cmd.execute && scr_v;
        out_screen_value <= (cmd.execute && scr_v) ? rv : 8'd0;
        out_bad_opcode <= cmd.execute && is_bad;
        out_program_counter <= cmd.execute ? pc_nxt : pc_r;
        out_halted <= halt_r | (cmd.execute && op == OP_HALT);
      end
    end
  end

  assign stat.func = func_r;
  assign stat.halted = halt_r;
  assign stat.op = op;
endmodule
`default_nettype wire

>>> hdl/vole_ctrl.sv
`default_nettype none
module vole_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  output logic                    out_valid,
  output logic                    clr_we,
  output logic [7:0]              clr_addr,
  input  wire vole_pkg::vole_stat_t stat,
  output vole_pkg::vole_cmd_t     cmd
);
  import vole_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_HI, S_LO, S_OPER, S_RUN, S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic [MEM_AW:0] clr_r, clr_nxt;
  logic valid_nxt;

  assign clr_we = (state_r == S_CLEAR);
  assign clr_addr = 8'(clr_r[MEM_AW-1:0]);
  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    clr_nxt = clr_r;
    valid_nxt = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (MEM_AW+1)'(MEM_DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.cap_in = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.func == FUNC_EXEC && !stat.halted) begin
          cmd.mem_rd_pc = 1'b1;
          state_nxt = S_HI;
        end else if (stat.func == FUNC_WRITE) begin
          cmd.mem_wr_in = 1'b1;
          cmd.finish = 1'b1;
          valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.mem_rd_a = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_HI: begin
        cmd.mem_rd_pc1 = 1'b1;
        cmd.cap_hi = 1'b1;
        state_nxt = S_LO;
      end
      S_LO: begin
        cmd.cap_lo = 1'b1;
        state_nxt = S_OPER;
      end
      // The operand byte at the low byte address arrives in the cycle after its read.
      S_OPER: begin
        cmd.mem_rd_lo = 1'b1;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        cmd.execute = 1'b1;
        cmd.finish = 1'b1;
        valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      S_EXEC: begin
        cmd.finish = 1'b1;
        valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      out_valid <= valid_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_start_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> busy) else $error("idle during clear");
  a_valid_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held");
  a_exec_after_lo: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute |-> $past(cmd.mem_rd_lo)) else $error("execute without fetch");
`endif
endmodule
`default_nettype wire

>>> hdl/vole_cpu_instruction_step_top.sv
`default_nettype none
// Vole 8-bit CPU step engine.
// Pulse start with in_func/in_address/in_data while busy is low. Each word
// produces one result, shown for one cycle while out_valid is high.
// in_func: write memory, execute one instruction, read memory, read register.
// A write completes in the dispatch state; reads, and execute while halted,
// also pass the exec state for the registered memory read; an executed instruction
// passes the hi, lo, operand and run states. One word in flight; busy drops in the
// cycle the result is shown, so the next word can be taken at that edge.
// An instruction needs two fetch reads and one operand read in sequence, each
// through the registered memory read port.
// cfg_we with cfg_data sets the start address and loads the program counter.
// After reset busy stays high while the memory is zeroed;
// registers, halt flag and pc (to 10) reset at once.
// The receiver cannot stall: each result must be taken in its cycle.
module vole_cpu_instruction_step_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_func,
  input  wire logic [7:0]  in_address,
  input  wire logic [7:0]  in_data,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_data,
  output logic             out_valid,
  output logic [7:0]       out_read_data,
  output logic [7:0]       out_program_counter,
  output logic [15:0]      out_instruction,
  output logic             out_screen_valid,
  output logic [7:0]       out_screen_value,
  output logic             out_halted,
  output logic             out_bad_opcode
);
  import vole_pkg::*;

  vole_cmd_t  cmd;
  vole_stat_t stat;
  logic       clr_we;
  logic [7:0] clr_addr;

  vole_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
    .clr_we(clr_we), .clr_addr(clr_addr), .stat(stat), .cmd(cmd)
  );

  vole_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .clr_we(clr_we),
    .clr_addr(clr_addr), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_func(in_func), .in_address(in_address), .in_data(in_data),
    .out_read_data(out_read_data), .out_program_counter(out_program_counter),
    .out_instruction(out_instruction), .out_screen_valid(out_screen_valid),
    .out_screen_value(out_screen_value), .out_halted(out_halted),
    .out_bad_opcode(out_bad_opcode)
  );
endmodule
`default_nettype wire

>>> verif/tb_vole_cpu_instruction_step_top.sv
`timescale 1ns / 1ps
module tb_vole_cpu_instruction_step_top;
  import vole_pkg::*;

  typedef struct {
    logic [1:0] func;
    logic [7:0] addr;
    logic [7:0] data;
    bit         burst;
  } word_t;

  typedef struct {
    logic [7:0]  read_data;
    logic [7:0]  pc;
    logic [15:0] instr;
    logic        scr_valid;
    logic [7:0]  scr_value;
    logic        halted;
    logic        bad;
  } step_result_t;

  localparam int IDLE_LIMIT = 3000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_func = FUNC_WRITE;
  logic [7:0] in_address = 8'd0;
  logic [7:0] in_data = 8'd0;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_data = 8'd0;
  logic out_valid;
  logic [7:0] out_read_data;
  logic [7:0] out_program_counter;
  logic [15:0] out_instruction;
  logic out_screen_valid;
  logic [7:0] out_screen_value;
  logic out_halted;
  logic out_bad_opcode;

  // Shadow machine state, advanced in the order words are queued.
  logic [7:0] shadow_mem [MEM_DEPTH];
  logic [7:0] shadow_regs [REG_COUNT];
  logic [7:0] shadow_pc;
  logic       shadow_halt;

  word_t        word_q [$];
  step_result_t predicted_q [$];
  step_result_t awaited_q [$];
  int  errors = 0;
  int  idle_cycles = 0;
  bit  no_gaps = 1'b0;

  vole_cpu_instruction_step_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_address(in_address), .in_data(in_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_read_data(out_read_data),
    .out_program_counter(out_program_counter), .out_instruction(out_instruction),
    .out_screen_valid(out_screen_valid), .out_screen_value(out_screen_value),
    .out_halted(out_halted), .out_bad_opcode(out_bad_opcode)
  );

  always #10 clk = ~clk;

  function automatic logic [7:0] fp_add(logic [7:0] a, logic [7:0] b);
    int va, vb, total, mag, msb, ex;
    logic [3:0] man;
    va = int'(a[3:0]) << a[6:4];
    vb = int'(b[3:0]) << b[6:4];
    if (a[7]) va = -va;
    if (b[7]) vb = -vb;
    total = va + vb;
    mag = (total < 0) ? -total : total;
    if (mag == 0) return 8'h00;
    msb = 0;
    for (int i = 0; i < 16; i++) if (mag[i]) msb = i;
    if (msb <= 3) begin
      ex = 0;
      man = 4'(mag);
    end else if (msb - 3 > 7) begin
      ex = 7;
      man = 4'hF;
    end else begin
      ex = msb - 3;
      man = 4'(mag >> ex);
    end
    return {(total < 0), 3'(ex), man};
  endfunction

  function automatic step_result_t cpu_step(word_t w);
    step_result_t r;
    logic [7:0] hi, lo, nxt, rv;
    logic [3:0] op, rn, xn, yn;
    r = '{default: '0};
    case (w.func)
      FUNC_WRITE: shadow_mem[w.addr % MEM_DEPTH] = w.data;
      FUNC_RDMEM: r.read_data = shadow_mem[w.addr % MEM_DEPTH];
      FUNC_RDREG: r.read_data = shadow_regs[w.addr[3:0]];
      default: begin
        if (!shadow_halt) begin
          hi = shadow_mem[shadow_pc % MEM_DEPTH];
          lo = shadow_mem[8'(shadow_pc + 8'd1) % MEM_DEPTH];
          {op, rn} = hi;
          {xn, yn} = lo;
          nxt = shadow_pc + 8'd2;
          r.instr = {hi, lo};
          rv = shadow_regs[rn];
          case (op)
            OP_LOAD:  shadow_regs[rn] = shadow_mem[lo % MEM_DEPTH];
            OP_LDI:   shadow_regs[rn] = lo;
            OP_STORE: begin
              shadow_mem[lo % MEM_DEPTH] = rv;
              if (lo == 8'd0) begin
                r.scr_valid = 1'b1;
                r.scr_value = rv;
              end
            end
            OP_MOVE:  shadow_regs[yn] = shadow_regs[xn];
            OP_ADD:   shadow_regs[rn] = shadow_regs[xn] + shadow_regs[yn];
            OP_FADD:  shadow_regs[rn] = fp_add(shadow_regs[xn], shadow_regs[yn]);
            OP_OR:    shadow_regs[rn] = shadow_regs[xn] | shadow_regs[yn];
            OP_AND:   shadow_regs[rn] = shadow_regs[xn] & shadow_regs[yn];
            OP_XOR:   shadow_regs[rn] = shadow_regs[xn] ^ shadow_regs[yn];
            OP_ROT:   shadow_regs[rn] = (rv >> yn[2:0]) | (rv << (4'd8 - yn[2:0]));
            OP_JEQ:   if (rv == shadow_regs[0]) nxt = lo;
            OP_HALT:  shadow_halt = 1'b1;
            OP_JGT:   if ($signed(rv) > $signed(shadow_regs[0])) nxt = lo;
            default:  r.bad = 1'b1;
          endcase
          shadow_pc = nxt;
        end
      end
    endcase
    r.pc = shadow_pc;
    r.halted = shadow_halt;
    return r;
  endfunction

  task automatic queue_word(logic [1:0] f, logic [7:0] a, logic [7:0] d);
    word_t w;
    w = '{func: f, addr: a, data: d, burst: no_gaps};
    predicted_q.insert(predicted_q.size(), cpu_step(w));
    word_q.insert(word_q.size(), w);
  endtask

  // Place an instruction at the current program counter and execute it.
  task automatic run_instr(logic [7:0] hi, logic [7:0] lo);
    queue_word(FUNC_WRITE, shadow_pc, hi);
    queue_word(FUNC_WRITE, shadow_pc + 8'd1, lo);
    queue_word(FUNC_EXEC, 8'd0, 8'd0);
  endtask

  task automatic set_start_address(logic [7:0] value);
    while (word_q.size() != 0 || awaited_q.size() != 0 || start) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_pc = value;
    @(negedge clk);
  endtask

  task automatic random_items(int count);
    logic [3:0] op;
    int sel;
    for (int i = 0; i < count; i++) begin
      no_gaps = (i >= count / 2) && (i < count / 2 + 120);
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        op = 4'($urandom_range(0, 15));
        if (op == OP_HALT || $urandom_range(0, 3) == 0) op = OP_LDI;
        run_instr({op, 4'($urandom)}, 8'($urandom));
        i += 2;
      end else if (sel < 80) begin
        queue_word(FUNC_WRITE, 8'($urandom), 8'($urandom));
      end else if (sel < 87) begin
        queue_word(FUNC_RDMEM, 8'($urandom), 8'($urandom));
      end else if (sel < 94) begin
        queue_word(FUNC_RDREG, 8'($urandom), 8'($urandom));
      end else if (shadow_mem[shadow_pc % MEM_DEPTH][7:4] != OP_HALT) begin
        queue_word(FUNC_EXEC, 8'($urandom), 8'($urandom));
      end
    end
    no_gaps = 1'b0;
  endtask

  // Driver: one word on the ports; it is taken at an edge with start high and busy low.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        awaited_q.insert(awaited_q.size(), predicted_q.pop_front());
        word_q.delete(0);
      end
      if (!(start && busy)) begin
        if (word_q.size() != 0 && (word_q[0].burst || $urandom_range(0, 99) >= 35)) begin
          start <= 1'b1;
          in_func <= word_q[0].func;
          in_address <= word_q[0].addr;
          in_data <= word_q[0].data;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: mismatch on %s: expected %h, actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    step_result_t e;
    if (rst_n && out_valid) begin
      if (awaited_q.size() == 0) begin
        $display("%0t: result with no word outstanding: expected none, actual pc %h",
                 $time, out_program_counter);
        errors++;
      end else begin
        e = awaited_q.pop_front();
        check_field("read_data", e.read_data, out_read_data);
        check_field("program_counter", e.pc, out_program_counter);
        check_field("instruction", e.instr, out_instruction);
        check_field("screen_valid", e.scr_valid, out_screen_valid);
        check_field("screen_value", e.scr_value, out_screen_value);
        check_field("halted", e.halted, out_halted);
        check_field("bad_opcode", e.bad, out_bad_opcode);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < MEM_DEPTH; i++) shadow_mem[i] = 8'd0;
    for (int i = 0; i < REG_COUNT; i++) shadow_regs[i] = 8'd0;
    shadow_pc = START_RESET;
    shadow_halt = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Extremes of memory and register access at the reset start address.
    queue_word(FUNC_WRITE, 8'hFF, 8'hFF);
    queue_word(FUNC_RDMEM, 8'hFF, 8'h00);
    queue_word(FUNC_RDREG, 8'hFF, 8'hFF);
    run_instr({OP_LDI, 4'h1}, 8'h7F);
    run_instr({OP_LDI, 4'hF}, 8'hF7);

    // Fetch across the top of memory, so pc wraps.
    set_start_address(8'hFE);
    run_instr({OP_FADD, 4'h2}, 8'h11);
    run_instr({OP_FADD, 4'h3}, 8'h1F);
    run_instr({OP_ADD, 4'h4}, 8'h1F);
    run_instr({OP_STORE, 4'h1}, 8'h00);
    run_instr({OP_MOVE, 4'h0}, 8'h1E);
    run_instr({OP_OR, 4'h5}, 8'h1F);
    run_instr({OP_AND, 4'h6}, 8'h1F);
    run_instr({OP_XOR, 4'h7}, 8'hFF);
    run_instr({OP_ROT, 4'h1}, 8'h0F);
    run_instr({OP_LOAD, 4'h8}, 8'hFF);
    run_instr({OP_JEQ, 4'h0}, 8'h40);
    run_instr({OP_JGT, 4'h1}, 8'h80);
    run_instr(8'h00, 8'h00);
    run_instr(8'hE5, 8'h55);
    run_instr(8'hFF, 8'hFF);

    random_items(500);
    set_start_address(8'h00);
    random_items(450);
    set_start_address(8'hFF);
    random_items(450);
    set_start_address(8'($urandom));
    random_items(450);

    // Halt last: afterwards execute words must leave everything unchanged.
    run_instr({OP_HALT, 4'h0}, 8'h00);
    queue_word(FUNC_EXEC, 8'h00, 8'h00);
    queue_word(FUNC_RDREG, 8'h01, 8'h00);
    queue_word(FUNC_EXEC, 8'hFF, 8'hFF);

    while (word_q.size() != 0 || awaited_q.size() != 0 || start) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

>>> sim.f
hdl/vole_pkg.sv
hdl/vole_ram.sv
hdl/vole_datapath.sv
hdl/vole_ctrl.sv
hdl/vole_cpu_instruction_step_top.sv
verif/tb_vole_cpu_instruction_step_top.sv
